// File: sv/sync_frame_parser_value_table_macros.svh
// Assertion macros used by the checker file of the frame parser.
`ifndef SYNC_FRAME_PARSER_VALUE_TABLE_MACROS_SVH
`define SYNC_FRAME_PARSER_VALUE_TABLE_MACROS_SVH

// Same-cycle implication, quiet while reset is asserted.
`define SFPVT_ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("sfpvt assertion failed");

// Next-cycle implication, quiet while reset is asserted.
`define SFPVT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("sfpvt assertion failed");

`endif

// File: sv/sfpvt_pkg.sv
// Types, constants and controller/datapath links of the frame parser.
package sfpvt_pkg;

	localparam int FRAME_BYTES = 256;
	localparam int BUF_AW = $clog2(FRAME_BYTES);
	localparam int IDX_W = $clog2(FRAME_BYTES + 1);
	localparam int TBL_DEPTH = 256;
	localparam int TBL_AW = $clog2(TBL_DEPTH);
	localparam int HDR_BYTES = 3;
	localparam int TRIPLE_BYTES = 3;

	localparam logic [7:0] SYNC_BYTE = 8'hFF;
	localparam logic [7:0] END_ID = 8'h00;
	localparam logic [1:0] SYNC_LEN = 2'd3;
	localparam logic [1:0] PHASE_LAST = 2'd2;

	localparam logic signed [11:0] ANGLE_MUL = 12'sd1125;
	localparam int ANGLE_SHIFT = 9;
	localparam int PROD_W = 28;

	typedef enum logic {
		CMD_BYTE,
		CMD_READ
	} cmd_code_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_WALK_ID,
		ST_WALK_LO,
		ST_WALK_HI,
		ST_WALK_WR
	} state_t;

	typedef enum logic [1:0] {
		OFF_ID,
		OFF_LO,
		OFF_HI
	} rd_off_t;

	typedef struct packed {
		logic    take_byte;
		logic    load_read;
		rd_off_t rd_off;
		logic    latch_id;
		logic    latch_lo;
		logic    tbl_wr;
	} dp_cmd_t;

	typedef struct packed {
		logic out_free;
		logic walk_start;
		logic walk_more;
	} dp_stat_t;

endpackage

// File: sv/sfpvt_in_if.sv
// Input channel: received byte or table read request.
interface sfpvt_in_if;
	logic       valid;
	logic       ready;
	logic       command;
	logic [7:0] byte_value;
	logic [7:0] read_id;

	modport source (output valid, command, byte_value, read_id, input ready);
	modport sink (input valid, command, byte_value, read_id, output ready);
endinterface

// File: sv/sfpvt_out_if.sv
// Output channel: frame status or table entry with its angle.
interface sfpvt_out_if;
	logic               valid;
	logic               ready;
	logic               frame_done;
	logic               frame_dropped;
	logic signed [15:0] raw_value;
	logic signed [17:0] angle_hundredths;

	modport source (output valid, frame_done, frame_dropped, raw_value, angle_hundredths,
		input ready);
	modport sink (input valid, frame_done, frame_dropped, raw_value, angle_hundredths,
		output ready);
endinterface

// File: sv/sfpvt_ctrl.sv
// Controller: input handshake, table read sequencing and frame commit walk.
module sfpvt_ctrl import sfpvt_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	input  logic     in_command,
	output logic     in_ready,
	input  dp_stat_t stat,
	output dp_cmd_t  cmd
);

	state_t state_q, state_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_n;
		end
	end

	always_comb begin
		state_n = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid && stat.out_free) begin
					if (in_command == CMD_READ) begin
						state_n = ST_READ;
					end else if (stat.walk_start) begin
						state_n = ST_WALK_ID;
					end
				end
			end
			ST_READ:    state_n = ST_IDLE;
			ST_WALK_ID: state_n = ST_WALK_LO;
			ST_WALK_LO: state_n = ST_WALK_HI;
			ST_WALK_HI: state_n = ST_WALK_WR;
			ST_WALK_WR: state_n = stat.walk_more ? ST_WALK_ID : ST_IDLE;
			default:    state_n = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = stat.out_free;
				cmd.take_byte = in_valid && stat.out_free && (in_command == CMD_BYTE);
			end
			ST_READ: cmd.load_read = 1'b1;
			ST_WALK_ID: cmd.rd_off = OFF_ID;
			ST_WALK_LO: begin
				cmd.latch_id = 1'b1;
				cmd.rd_off = OFF_LO;
			end
			ST_WALK_HI: begin
				cmd.latch_lo = 1'b1;
				cmd.rd_off = OFF_HI;
			end
			ST_WALK_WR: cmd.tbl_wr = 1'b1;
			default: ;
		endcase
	end

endmodule

// File: sv/sfpvt_dp.sv
// Datapath: parser state, frame buffer, value table and output register.
module sfpvt_dp import sfpvt_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  dp_cmd_t            cmd,
	input  logic [7:0]         byte_value,
	input  logic [7:0]         read_id,
	input  logic               out_ready,
	output dp_stat_t           stat,
	output logic               out_valid,
	output logic               frame_done,
	output logic               frame_dropped,
	output logic signed [15:0] raw_value,
	output logic signed [17:0] angle_hundredths
);

	// parser state
	logic [1:0]       sync_run_q, sync_n;
	logic             in_frame_q, in_frame_n;
	logic [IDX_W-1:0] byte_index_q, idx_n;
	logic [1:0]       field_phase_q, field_n;
	logic [1:0]       trailer_phase_q, trailer_n;
	logic             end_seen_q, end_n;
	logic             overflowed_q, ovf_n;
	logic             store_en;
	logic             commit;
	logic             sync_hit;

	// commit walk
	logic [IDX_W-1:0]  walk_lim_q;
	logic [BUF_AW-1:0] walk_ptr_q;
	logic [BUF_AW-1:0] fb_addr;
	logic [7:0]        fb_rd_q;
	logic [7:0]        id_q;
	logic [7:0]        lo_q;
	logic [7:0]        fb_mem [FRAME_BYTES];

	// value table
	logic [15:0]          tbl_mem [TBL_DEPTH];
	logic [TBL_DEPTH-1:0] tbl_vld_q;
	logic [15:0]          tbl_rd_q;
	logic                 tbl_rd_vld_q;
	logic signed [15:0]   raw_rd;
	logic signed [PROD_W-1:0] prod;

	// output register
	logic               out_valid_q;
	logic               done_q;
	logic               dropped_q;
	logic signed [15:0] raw_q;
	logic signed [17:0] angle_q;

	always_comb begin
		sync_n = sync_run_q;
		in_frame_n = in_frame_q;
		idx_n = byte_index_q;
		field_n = field_phase_q;
		trailer_n = trailer_phase_q;
		end_n = end_seen_q;
		ovf_n = overflowed_q;
		store_en = 1'b0;
		commit = 1'b0;
		sync_hit = 1'b0;
		if (byte_value == SYNC_BYTE) begin
			sync_n = sync_run_q + 2'd1;
			if (sync_n == SYNC_LEN) begin
				// restart the frame, phases stay as they are
				sync_hit = 1'b1;
				in_frame_n = 1'b1;
				sync_n = '0;
				idx_n = '0;
				ovf_n = 1'b0;
			end
		end else begin
			sync_n = '0;
		end
		if (!sync_hit) begin
			if (in_frame_q) begin
				if (byte_index_q < IDX_W'(FRAME_BYTES)) begin
					store_en = 1'b1;
					idx_n = byte_index_q + 1'b1;
				end else begin
					ovf_n = 1'b1;
				end
				if (byte_index_q > IDX_W'(HDR_BYTES - 1)) begin
					field_n = (field_phase_q < PHASE_LAST) ? field_phase_q + 2'd1 : '0;
				end
			end
			if (field_n == '0 && byte_value == END_ID && trailer_phase_q >= PHASE_LAST) begin
				end_n = 1'b1;
				trailer_n = '0;
			end else begin
				if (trailer_phase_q < PHASE_LAST) begin
					trailer_n = trailer_phase_q + 2'd1;
				end
				if (end_seen_q && trailer_n >= PHASE_LAST) begin
					commit = 1'b1;
				end
			end
		end
	end

	// first triple sits right after the header
	assign stat.walk_start = commit && !ovf_n &&
		(idx_n > IDX_W'(HDR_BYTES + TRIPLE_BYTES - 1));
	assign stat.walk_more = ((IDX_W + 1)'(walk_ptr_q) +
		(IDX_W + 1)'(2 * TRIPLE_BYTES - 1)) < {1'b0, walk_lim_q};
	assign stat.out_free = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sync_run_q <= '0;
			in_frame_q <= 1'b0;
			byte_index_q <= '0;
			field_phase_q <= PHASE_LAST;
			trailer_phase_q <= PHASE_LAST;
			end_seen_q <= 1'b0;
			overflowed_q <= 1'b0;
			walk_lim_q <= '0;
			walk_ptr_q <= '0;
		end else begin
			if (cmd.take_byte) begin
				if (commit) begin
					sync_run_q <= '0;
					in_frame_q <= 1'b0;
					byte_index_q <= '0;
					field_phase_q <= PHASE_LAST;
					trailer_phase_q <= PHASE_LAST;
					end_seen_q <= 1'b0;
					overflowed_q <= 1'b0;
					walk_lim_q <= idx_n;
					walk_ptr_q <= BUF_AW'(HDR_BYTES);
				end else begin
					sync_run_q <= sync_n;
					in_frame_q <= in_frame_n;
					byte_index_q <= idx_n;
					field_phase_q <= field_n;
					trailer_phase_q <= trailer_n;
					end_seen_q <= end_n;
					overflowed_q <= ovf_n;
				end
			end
			if (cmd.tbl_wr) begin
				walk_ptr_q <= walk_ptr_q + BUF_AW'(TRIPLE_BYTES);
			end
		end
	end

	always_comb begin
		case (cmd.rd_off)
			OFF_ID:  fb_addr = walk_ptr_q;
			OFF_LO:  fb_addr = walk_ptr_q + BUF_AW'(1);
			OFF_HI:  fb_addr = walk_ptr_q + BUF_AW'(2);
			default: fb_addr = walk_ptr_q;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.take_byte && store_en) begin
			fb_mem[byte_index_q[BUF_AW-1:0]] <= byte_value;
		end
		fb_rd_q <= fb_mem[fb_addr];
	end

	always_ff @(posedge clk) begin
		if (cmd.latch_id) begin
			id_q <= fb_rd_q;
		end
		if (cmd.latch_lo) begin
			lo_q <= fb_rd_q;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.tbl_wr) begin
			tbl_mem[id_q] <= {fb_rd_q, lo_q};
		end
		tbl_rd_q <= tbl_mem[read_id];
	end

	// an entry never written reads as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tbl_vld_q <= '0;
			tbl_rd_vld_q <= 1'b0;
		end else begin
			if (cmd.tbl_wr) begin
				tbl_vld_q[id_q] <= 1'b1;
			end
			tbl_rd_vld_q <= tbl_vld_q[read_id];
		end
	end

	assign raw_rd = tbl_rd_vld_q ? tbl_rd_q : '0;
	assign prod = PROD_W'(raw_rd) * PROD_W'(ANGLE_MUL);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.take_byte || cmd.load_read) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take_byte) begin
			done_q <= commit;
			dropped_q <= commit && ovf_n;
			raw_q <= '0;
			angle_q <= '0;
		end else if (cmd.load_read) begin
			done_q <= 1'b0;
			dropped_q <= 1'b0;
			raw_q <= raw_rd;
			// arithmetic shift gives the floor
			angle_q <= prod[ANGLE_SHIFT+17:ANGLE_SHIFT];
		end
	end

	assign out_valid = out_valid_q;
	assign frame_done = done_q;
	assign frame_dropped = dropped_q;
	assign raw_value = raw_q;
	assign angle_hundredths = angle_q;

endmodule

// File: sv/sync_frame_parser_value_table.sv
// Sync frame parser with a 256-entry value table: a received byte's status is registered into
// the output register as the byte is taken; a table read is a registered table read, then the
// 1125/512 scaling multiply, and holds the input off meanwhile. The byte that completes a kept
// frame also starts a commit walk that holds the input off for each stored triple (id, low,
// high read one at a time over the frame buffer's single read port, then the table write).
// The table comes out of reset reading all zero through per-entry valid bits, with no clearing
// pass. A result waiting in the output register does not stop the next item from being
// accepted in the same cycle it is taken.
module sync_frame_parser_value_table import sfpvt_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	sfpvt_in_if.sink   in_ch,
	sfpvt_out_if.source out_ch
);

	dp_cmd_t  cmd;
	dp_stat_t stat;

	sfpvt_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_ch.valid),
		.in_command (in_ch.command),
		.in_ready   (in_ch.ready),
		.stat       (stat),
		.cmd        (cmd)
	);

	sfpvt_dp u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.byte_value       (in_ch.byte_value),
		.read_id          (in_ch.read_id),
		.out_ready        (out_ch.ready),
		.stat             (stat),
		.out_valid        (out_ch.valid),
		.frame_done       (out_ch.frame_done),
		.frame_dropped    (out_ch.frame_dropped),
		.raw_value        (out_ch.raw_value),
		.angle_hundredths (out_ch.angle_hundredths)
	);

endmodule

// File: sv/sfpvt_checker.sv
// Port-level checker for the frame parser, bound to the top level.
`include "sync_frame_parser_value_table_macros.svh"

module sfpvt_checker import sfpvt_pkg::*; (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_ready,
	input logic               in_command,
	input logic               out_valid,
	input logic               out_ready,
	input logic               frame_done,
	input logic               frame_dropped,
	input logic signed [15:0] raw_value,
	input logic signed [17:0] angle_hundredths
);

	logic in_acc;

	assign in_acc = in_valid && in_ready;

	// a read holds the input off while the table result is formed
	`SFPVT_ASSERT_NEXT(a_read_blocks, clk, arst_n, in_acc && in_command == CMD_READ, !in_ready)
	`SFPVT_ASSERT_IMPLIES(a_read_result, clk, arst_n, in_acc && in_command == CMD_READ, ##2 out_valid)
	`SFPVT_ASSERT_NEXT(a_byte_result, clk, arst_n, in_acc && in_command == CMD_BYTE, out_valid && raw_value == 16'sd0 && angle_hundredths == 18'sd0)
	`SFPVT_ASSERT_IMPLIES(a_drop_done, clk, arst_n, out_valid && frame_dropped, frame_done)
	`SFPVT_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(raw_value) && $stable(angle_hundredths) && $stable(frame_done))

endmodule

bind sync_frame_parser_value_table sfpvt_checker u_sfpvt_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.in_valid         (in_ch.valid),
	.in_ready         (in_ch.ready),
	.in_command       (in_ch.command),
	.out_valid        (out_ch.valid),
	.out_ready        (out_ch.ready),
	.frame_done       (out_ch.frame_done),
	.frame_dropped    (out_ch.frame_dropped),
	.raw_value        (out_ch.raw_value),
	.angle_hundredths (out_ch.angle_hundredths)
);

// File: tb/sv/sync_frame_parser_value_table_tb.sv
// Testbench for the frame parser: random byte streams and table reads checked by a scoreboard.
module sync_frame_parser_value_table_tb;
	import sfpvt_pkg::*;

	typedef struct packed {
		logic               done;
		logic               dropped;
		logic signed [15:0] raw;
		logic signed [17:0] angle;
	} frame_status_t;

	class frame_table_board;
		logic [1:0]    sync_run;
		bit            in_frame;
		int            byte_index;
		logic [1:0]    field_phase;
		logic [1:0]    trailer_phase;
		bit            end_seen;
		bit            overflowed;
		logic [7:0]    frame_buf[FRAME_BYTES];
		logic [15:0]   value_mem[256];
		frame_status_t expected_status[$];
		int            errors;

		function new();
			sync_run = 2'd0;
			in_frame = 1'b0;
			byte_index = 0;
			field_phase = PHASE_LAST;
			trailer_phase = PHASE_LAST;
			end_seen = 1'b0;
			overflowed = 1'b0;
			foreach (value_mem[i]) value_mem[i] = 16'h0000;
			errors = 0;
		endfunction

		function void parse_byte(logic [7:0] b, output logic done, output logic dropped);
			done = 1'b0;
			dropped = 1'b0;
			if (b == SYNC_BYTE) begin
				sync_run = sync_run + 2'd1;
				if (sync_run == SYNC_LEN) begin
					// restart the frame, phases stay as they are
					in_frame = 1'b1;
					sync_run = 2'd0;
					byte_index = 0;
					overflowed = 1'b0;
					return;
				end
			end else begin
				sync_run = 2'd0;
			end
			if (in_frame) begin
				if (byte_index < FRAME_BYTES)
					frame_buf[byte_index] = b;
				else
					overflowed = 1'b1;
				if (byte_index > 2)
					field_phase = (field_phase < PHASE_LAST) ? field_phase + 2'd1 : 2'd0;
				if (byte_index < FRAME_BYTES)
					byte_index++;
			end
			if (field_phase == 2'd0 && b == END_ID && trailer_phase >= PHASE_LAST) begin
				end_seen = 1'b1;
				trailer_phase = 2'd0;
				return;
			end
			if (trailer_phase < PHASE_LAST)
				trailer_phase = trailer_phase + 2'd1;
			if (end_seen && trailer_phase >= PHASE_LAST) begin
				done = 1'b1;
				if (overflowed) begin
					dropped = 1'b1;
				end else begin
					// walk the stored triples, end marker included
					for (int i = 3; i + 2 < byte_index && i + 2 < FRAME_BYTES; i += 3)
						value_mem[frame_buf[i]] = {frame_buf[i + 2], frame_buf[i + 1]};
				end
				in_frame = 1'b0;
				byte_index = 0;
				sync_run = 2'd0;
				field_phase = PHASE_LAST;
				trailer_phase = PHASE_LAST;
				end_seen = 1'b0;
				overflowed = 1'b0;
			end
		endfunction

		function void note_accepted(cmd_code_t cmd, logic [7:0] b, logic [7:0] rid);
			frame_status_t exp;
			logic signed [27:0] prod;
			logic d;
			logic dr;
			exp = '0;
			if (cmd == CMD_READ) begin
				exp.raw = value_mem[rid];
				prod = 28'($signed(exp.raw)) * 28'sd1125;
				exp.angle = 18'(prod >>> 9);
			end else begin
				parse_byte(b, d, dr);
				exp.done = d;
				exp.dropped = dr;
			end
			expected_status.push_back(exp);
		endfunction

		function void check_result(logic done, logic dropped, logic signed [15:0] raw,
				logic signed [17:0] angle);
			frame_status_t exp;
			if (expected_status.size() == 0) begin
				$display("%0t: unexpected result done=%0b dropped=%0b raw=%0d angle=%0d",
					$time, done, dropped, raw, angle);
				errors++;
				return;
			end
			exp = expected_status.pop_front();
			if ({done, dropped, raw, angle} !== exp) begin
				$display({"%0t: expected done=%0b dropped=%0b raw=%0d angle=%0d,",
					" actual done=%0b dropped=%0b raw=%0d angle=%0d"},
					$time, exp.done, exp.dropped, $signed(exp.raw), $signed(exp.angle),
					done, dropped, raw, angle);
				errors++;
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;

	sfpvt_in_if  in_ch();
	sfpvt_out_if out_ch();

	sync_frame_parser_value_table uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_ch),
		.out_ch(out_ch)
	);

	frame_table_board board = new();

	logic [7:0] id_pool[8];
	int         items_sent;
	int         gap_pct;
	int         stall_pct;
	bit         calm;
	int         results_seen;
	int         stall_left;
	bit         pressure_done;
	int         choice;

	always #4 clk = ~clk;

	initial begin
		#2000000;
		$display("sync_frame_parser_value_table: mismatch");
		$finish;
	end

	function automatic logic [7:0] pick_id(bit with_end);
		if (with_end && $urandom_range(0, 3) == 0)
			return END_ID;
		if ($urandom_range(0, 1) == 0)
			return id_pool[$urandom_range(0, 7)];
		return 8'($urandom_range(1, 255));
	endfunction

	task automatic send_item(cmd_code_t cmd, logic [7:0] b, logic [7:0] rid);
		if (!calm && gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
			in_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 9)) @(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.command <= cmd;
		in_ch.byte_value <= b;
		in_ch.read_id <= rid;
		do @(posedge clk); while (!in_ch.ready);
		board.note_accepted(cmd, b, rid);
		items_sent++;
	endtask

	task automatic send_byte(logic [7:0] b);
		send_item(CMD_BYTE, b, 8'($urandom_range(0, 255)));
	endtask

	task automatic send_read(logic [7:0] rid);
		send_item(CMD_READ, 8'($urandom_range(0, 255)), rid);
	endtask

	// sync, header, triples, then optionally the end marker and trailer
	task automatic send_frame(int triples, bit finish);
		repeat (3) send_byte(SYNC_BYTE);
		repeat (3) send_byte(8'($urandom_range(0, 255)));
		for (int t = 0; t < triples; t++) begin
			if ($urandom_range(0, 5) == 0)
				send_read(pick_id(1'b1));
			send_byte(pick_id(1'b0));
			send_byte(8'($urandom_range(0, 255)));
			send_byte(8'($urandom_range(0, 255)));
		end
		if (finish) begin
			send_byte(END_ID);
			send_byte(8'($urandom_range(0, 255)));
			send_byte(8'($urandom_range(0, 255)));
		end
	endtask

	// receiver: check each transaction, then pick the next ready
	initial begin
		out_ch.ready <= 1'b0;
		results_seen = 0;
		stall_left = 0;
		pressure_done = 1'b0;
		stall_pct = 20;
		forever begin
			@(posedge clk);
			if (out_ch.valid && out_ch.ready) begin
				board.check_result(out_ch.frame_done, out_ch.frame_dropped,
					out_ch.raw_value, out_ch.angle_hundredths);
				results_seen++;
			end
			if (!pressure_done && results_seen >= 300) begin
				// hold off long enough for the input to back up
				pressure_done = 1'b1;
				stall_left = 400;
			end
			if ($urandom_range(0, 49) == 0)
				case ($urandom_range(0, 2))
					0: stall_pct = 0;
					1: stall_pct = 15;
					default: stall_pct = 40;
				endcase
			if (stall_left > 0) begin
				out_ch.ready <= 1'b0;
				stall_left--;
			end else if (!calm && arst_n && $urandom_range(0, 99) < stall_pct) begin
				out_ch.ready <= 1'b0;
				stall_left = $urandom_range(1, 9) - 1;
			end else begin
				out_ch.ready <= 1'b1;
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		in_ch.valid <= 1'b0;
		in_ch.command <= CMD_BYTE;
		in_ch.byte_value <= 8'h00;
		in_ch.read_id <= 8'h00;
		items_sent = 0;
		gap_pct = 30;
		calm = 1'b0;
		foreach (id_pool[i]) id_pool[i] = 8'($urandom_range(1, 255));
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// table reads as zero out of reset
		send_read(8'h00);
		send_read(8'hFF);
		// one frame hitting both value extremes, a zero low byte and a lone 0xFF
		repeat (3) send_byte(SYNC_BYTE);
		send_byte(8'h01);
		send_byte(8'h02);
		send_byte(8'h03);
		send_byte(8'h80);
		send_byte(8'h00);
		send_byte(8'h80);
		send_byte(8'h7F);
		send_byte(8'hFF);
		send_byte(8'h7F);
		send_byte(END_ID);
		send_byte(8'h01);
		send_byte(8'h00);
		send_read(8'h80);
		send_read(8'h7F);
		send_read(END_ID);

		// a frame too long for the buffer is dropped
		send_frame($urandom_range(85, 88), 1'b1);

		while (items_sent < 750) begin
			calm = (items_sent >= 650);
			case ($urandom_range(0, 3))
				0: gap_pct = 0;
				1: gap_pct = 10;
				default: gap_pct = 40;
			endcase
			choice = $urandom_range(0, 99);
			if (choice < 55)
				send_frame(($urandom_range(0, 19) == 0) ? $urandom_range(10, 60)
					: $urandom_range(0, 6), 1'b1);
			else if (choice < 65)
				send_frame($urandom_range(0, 4), 1'b0);
			else if (choice < 85)
				repeat ($urandom_range(1, 4)) send_read(pick_id(1'b1));
			else
				repeat ($urandom_range(1, 6))
					case ($urandom_range(0, 2))
						0: send_byte(SYNC_BYTE);
						1: send_byte(END_ID);
						default: send_byte(8'($urandom_range(0, 255)));
					endcase
		end
		in_ch.valid <= 1'b0;

		while (board.expected_status.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (board.errors == 0)
			$display("sync_frame_parser_value_table: match");
		else
			$display("sync_frame_parser_value_table: mismatch");
		$finish;
	end

endmodule
